### hw/rtl/bpg_pkg.sv
`default_nettype none

package bpg_pkg;

   localparam int unsigned CFG_WIDTH     = 15;
   localparam int unsigned COUNT_WIDTH   = 7;
   localparam int unsigned TICK_WIDTH    = 16;
   localparam int unsigned CYCLE_WIDTH   = 8;
   localparam int unsigned REQ_DATA_BITS = 24;
   localparam int unsigned RSP_DATA_BITS = 8;

   localparam logic [CFG_WIDTH-1:0]   CYCLE_LENGTH_RESET = 15'd200;
   localparam logic [CFG_WIDTH-1:0]   ON_TIME_RESET      = 15'd100;
   localparam logic [COUNT_WIDTH-1:0] FOREVER_LIMIT      = 7'd100;

   typedef enum logic [1:0] {
      MODE_TICK      = 2'd0,
      MODE_FORCE_OFF = 2'd1,
      MODE_FORCE_ON  = 2'd2,
      MODE_BLINK     = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_CYCLE_LENGTH = 1'b0,
      CSR_ON_TIME      = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

### hw/rtl/beeper_pattern_generator.sv
`default_nettype none

// channel  dir  tdata (low bit up)                              tuser
// req_     in   beep_count[6:0] mute_count[13:7]                 mode[1:0]
//               repeat_count[20:14], zero pad [23:21]
// rsp_     out  buzzer_on[0] pattern_active[1], zero pad [7:2]   -
// csr_     in   csr_addr 0 cycle_length, 1 on_time; data [14:0]  -
//
// One beat per cycle sustained while rsp_tready stays high; a beat taken loads
// the input register, then the result register.
// The counter update is one short add/compare pass on the input register.
// Reset clears the pattern, the buzzer and both pipeline stages.
// rsp_tready low holds the result; the input register still drains into
// the result register as soon as that frees.

module beeper_pattern_generator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // beep_count, mute_count, repeat_count, zero pad
   input  wire logic [bpg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // buzzer_on, pattern_active, zero pad
   output logic [bpg_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic                             csr_addr,
   input  wire logic [bpg_pkg::CFG_WIDTH-1:0]    csr_wdata
);

   localparam int unsigned CW = bpg_pkg::COUNT_WIDTH;

   logic                                 in_valid_ff;
   bpg_pkg::mode_type                    in_mode_ff;
   logic [CW-1:0]                        in_beeps_ff;
   logic [CW-1:0]                        in_mutes_ff;
   logic [CW-1:0]                        in_repeat_ff;

   logic [bpg_pkg::CFG_WIDTH-1:0]        cycle_length_ff, cycle_length_in;
   logic [bpg_pkg::CFG_WIDTH-1:0]        on_time_ff, on_time_in;
   logic [bpg_pkg::TICK_WIDTH-1:0]       tick_ff, tick_in;
   logic [bpg_pkg::CYCLE_WIDTH-1:0]      cycle_ff, cycle_in;
   logic [CW-1:0]                        groups_done_ff, groups_done_in;
   logic [CW-1:0]                        beeps_ff, beeps_in;
   logic [CW-1:0]                        mutes_ff, mutes_in;
   logic [CW-1:0]                        wanted_ff, wanted_in;
   logic                                 level_ff, level_in;

   logic                                 out_valid_ff;
   logic                                 out_buzzer_ff;
   logic                                 out_active_ff;

   logic                                 advance;
   logic [bpg_pkg::TICK_WIDTH-1:0]       tick_inc;
   logic [bpg_pkg::CYCLE_WIDTH-1:0]      cycle_inc;
   logic [bpg_pkg::CYCLE_WIDTH-1:0]      group_len;
   logic [CW-1:0]                        groups_inc;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign tick_inc   = tick_ff + 1'b1;
   assign cycle_inc  = cycle_ff + 1'b1;
   assign group_len  = {1'b0, beeps_ff} + {1'b0, mutes_ff};
   assign groups_inc = groups_done_ff + 1'b1;

   always_comb begin
      cycle_length_in = cycle_length_ff;
      on_time_in      = on_time_ff;
      tick_in         = tick_ff;
      cycle_in        = cycle_ff;
      groups_done_in  = groups_done_ff;
      beeps_in        = beeps_ff;
      mutes_in        = mutes_ff;
      wanted_in       = wanted_ff;
      level_in        = level_ff;

      if (advance) begin
         case (in_mode_ff)
            bpg_pkg::MODE_TICK: begin
               if (beeps_ff != '0) begin
                  tick_in = tick_inc;
                  if (tick_inc >= {1'b0, cycle_length_ff}) begin
                     tick_in  = '0;
                     cycle_in = cycle_inc;
                     if (cycle_inc >= group_len) begin
                        cycle_in       = '0;
                        groups_done_in = groups_inc;
                        if (groups_inc >= wanted_ff) begin
                           groups_done_in = '0;
                           if (wanted_ff < bpg_pkg::FOREVER_LIMIT) begin
                              beeps_in = '0;
                           end
                        end
                     end
                  end else if (tick_inc >= {1'b0, on_time_ff}) begin
                     level_in = 1'b0;
                  end else if (cycle_ff < {1'b0, beeps_ff}) begin
                     level_in = 1'b1;
                  end
               end
            end
            bpg_pkg::MODE_FORCE_OFF: begin
               beeps_in = '0;
               level_in = 1'b0;
            end
            bpg_pkg::MODE_FORCE_ON: begin
               beeps_in = '0;
               level_in = 1'b1;
            end
            bpg_pkg::MODE_BLINK: begin
               beeps_in       = in_beeps_ff;
               mutes_in       = in_mutes_ff;
               wanted_in      = in_repeat_ff;
               cycle_in       = '0;
               groups_done_in = '0;
            end
            default: begin
               level_in = level_ff;
            end
         endcase
      end

      if (csr_we) begin
         case (csr_addr)
            bpg_pkg::CSR_CYCLE_LENGTH: cycle_length_in = csr_wdata;
            bpg_pkg::CSR_ON_TIME:      on_time_in      = csr_wdata;
            default:                   on_time_in      = on_time_ff;
         endcase
         tick_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         cycle_length_ff <= bpg_pkg::CYCLE_LENGTH_RESET;
         on_time_ff      <= bpg_pkg::ON_TIME_RESET;
         tick_ff         <= '0;
         cycle_ff        <= '0;
         groups_done_ff  <= '0;
         beeps_ff        <= '0;
         mutes_ff        <= '0;
         wanted_ff       <= '0;
         level_ff        <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         cycle_length_ff <= cycle_length_in;
         on_time_ff      <= on_time_in;
         tick_ff         <= tick_in;
         cycle_ff        <= cycle_in;
         groups_done_ff  <= groups_done_in;
         beeps_ff        <= beeps_in;
         mutes_ff        <= mutes_in;
         wanted_ff       <= wanted_in;
         level_ff        <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mode_ff   <= bpg_pkg::mode_type'(req_tuser);
         in_beeps_ff  <= req_tdata[CW-1:0];
         in_mutes_ff  <= req_tdata[2*CW-1:CW];
         in_repeat_ff <= req_tdata[3*CW-1:2*CW];
      end
      if (advance) begin
         out_buzzer_ff <= level_in;
         out_active_ff <= (beeps_in != '0);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(bpg_pkg::RSP_DATA_BITS-2){1'b0}}, out_active_ff, out_buzzer_ff};

`ifndef ASSERT_OFF
   a_force_on: assert property (@(posedge clock) disable iff (reset)
      advance && in_mode_ff == bpg_pkg::MODE_FORCE_ON |=> level_ff && beeps_ff == '0)
      else $error("force on did not set buzzer and cancel pattern");

   a_force_off: assert property (@(posedge clock) disable iff (reset)
      advance && in_mode_ff == bpg_pkg::MODE_FORCE_OFF |=> !level_ff && beeps_ff == '0)
      else $error("force off did not clear buzzer and cancel pattern");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      advance && in_mode_ff == bpg_pkg::MODE_TICK && beeps_ff == '0 && !csr_we
      |=> $stable(tick_ff) && $stable(level_ff) && $stable(cycle_ff))
      else $error("tick without pattern changed state");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(advance)
      |-> rsp_tvalid && out_active_ff == (beeps_ff != '0) && out_buzzer_ff == level_ff)
      else $error("result register disagrees with pattern state");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire
